// ===== sv/fhc_pkg.sv =====
package fhc_pkg;

    localparam int NBUCKETS_DEF = 1024;
    localparam int WAYS_DEF     = 4;

    localparam int KEY_W       = 32;
    localparam int CMD_W       = 3;
    localparam int NB_W        = 11;
    localparam int BKT_W       = 10;
    localparam int SLOT_W      = 8;
    localparam int DSLOT_W     = 9;
    localparam int STAT_W      = 3;
    localparam int SHIFT_W     = 5;
    localparam int MODE_W      = 2;
    localparam int REG_IDX_W   = 3;
    localparam int CFG_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIGIT_W     = 4;

    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STAT_W-1:0] ST_DEFAULT = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISS    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD     = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_KEY_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_BUCKETS  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_SLOT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ADDR_SHIFT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ADDR_MASK    = 3'd4;

    localparam logic [MODE_W-1:0] KM_FULL = 2'd0;
    localparam logic [MODE_W-1:0] KM_PAIR = 2'd1;
    localparam logic [MODE_W-1:0] KM_FLOW = 2'd2;
    localparam logic [MODE_W-1:0] KM_DST  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  key_mode;
        logic [NB_W-1:0]    num_buckets;
        logic [DSLOT_W-1:0] default_slot;
        logic [SHIFT_W-1:0] addr_shift;
        logic [KEY_W-1:0]   addr_mask;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  src;
        logic [KEY_W-1:0]  dst;
        logic [KEY_W-1:0]  flow;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  src;
        logic [KEY_W-1:0]  dst;
        logic [KEY_W-1:0]  flow;
        logic [NB_W-1:0]   bucket;
        logic              bad;
        logic [SLOT_W-1:0] slot_value;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC
    } back_state_t;

    function automatic logic [KEY_W-1:0] fold(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] t;
        t = v ^ (v >> 16);
        t = t ^ (t >> 8);
        return t;
    endfunction

endpackage

// ===== sv/fhc_ram.sv =====
module fhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/fhc_fifo.sv =====
module fhc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = store[rd_ptr_reg];

    function automatic logic [PW-1:0] incr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= incr(wr_ptr_reg);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= incr(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/fhc_front.sv =====
module fhc_front import fhc_pkg::*; #(
    parameter int NBUCKETS = NBUCKETS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [KEY_W-1:0]  src_addr,
    input  logic [KEY_W-1:0]  dst_addr,
    input  logic [KEY_W-1:0]  flow_id,
    input  logic              bucket_auto,
    input  logic [BKT_W-1:0]  bucket_index,
    input  logic [SLOT_W-1:0] slot_value,
    input  logic              clearing,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job
);

    localparam int STEPS = KEY_W / DIGIT_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    front_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NB_W-1:0]   rem_reg, rem_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  s_reg, d_reg, f_reg;
    logic              auto_reg;
    logic [BKT_W-1:0]  bidx_reg;
    logic [SLOT_W-1:0] sv_reg;

    logic              accept, last;
    logic [NB_W-1:0]   nb_eff;
    logic [KEY_W-1:0]  hv, hv_sh;
    logic [NB_W-1:0]   bucket_sel;

    always_comb
    begin
        nb_eff = (cfg.num_buckets == '0) ? NB_W'(1) : cfg.num_buckets;
        if (32'(nb_eff) > NBUCKETS)
        begin
            nb_eff = NB_W'(NBUCKETS);
        end
    end

    always_comb
    begin
        case (cfg.key_mode)
            KM_FULL: hv = fold(s_reg ^ d_reg ^ f_reg);
            KM_PAIR: hv = fold(s_reg ^ d_reg);
            KM_FLOW: hv = f_reg;
            default: hv = d_reg;
        endcase
    end

    // one remainder digit per cycle, msb first
    always_comb
    begin
        logic [NB_W:0] t;
        hv_sh    = hv << {cnt_reg, 2'b00};
        rem_next = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            t = {rem_next, hv_sh[KEY_W-1-i]};
            if (t >= {1'b0, nb_eff})
            begin
                t = t - {1'b0, nb_eff};
            end
            rem_next = t[NB_W-1:0];
        end
    end

    assign last = (cnt_reg == CNT_W'(STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                if (last)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != F_IDLE) || clearing;
        accept   = in_valid && !in_stall;
        q_push   = (state_reg == F_PUSH) && !q_full;
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_CLASSIFY, CMD_DELETE: bucket_sel = rem_reg;
            CMD_INSERT, CMD_LOOKUP:   bucket_sel = auto_reg ? rem_reg : NB_W'(bidx_reg);
            default:                  bucket_sel = '0;
        endcase
        q_job.cmd        = cmd_reg;
        q_job.src        = s_reg;
        q_job.dst        = d_reg;
        q_job.flow       = f_reg;
        q_job.bucket     = bucket_sel;
        q_job.bad        = (cmd_reg inside {CMD_INSERT, CMD_LOOKUP}) && (bucket_sel >= nb_eff);
        q_job.slot_value = sv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            s_reg    <= (src_addr >> cfg.addr_shift) & cfg.addr_mask;
            d_reg    <= (dst_addr >> cfg.addr_shift) & cfg.addr_mask;
            f_reg    <= flow_id;
            auto_reg <= bucket_auto;
            bidx_reg <= bucket_index;
            sv_reg   <= slot_value;
            rem_reg  <= '0;
        end
        else if (state_reg == F_HASH)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == F_HASH)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

// ===== sv/fhc_back.sv =====
module fhc_back import fhc_pkg::*; #(
    parameter int NBUCKETS = NBUCKETS_DEF,
    parameter int WAYS     = WAYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    output logic              q_pop,
    input  job_t              q_job,
    output logic              clearing,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [SLOT_W-1:0] slot,
    output logic [BKT_W-1:0]  bucket
);

    localparam int AW    = (NBUCKETS > 1) ? $clog2(NBUCKETS) : 1;
    localparam int IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int PW    = $clog2(WAYS + 1) + 1;
    localparam int ROW_W = WAYS * $bits(entry_t);

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg;
    job_t              job_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [BKT_W-1:0]  bucket_reg;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;

    entry_t [WAYS-1:0] row, new_row;
    entry_t            ne;
    logic [WAYS-1:0]   match;
    logic              hit, out_free, load, row_write;
    logic [IW-1:0]     hit_idx;
    logic [STAT_W-1:0] res_status;
    logic [SLOT_W-1:0] res_slot;

    fhc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NBUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(q_job.bucket)),
        .rdata (ram_rdata)
    );

    assign row = ram_rdata;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            case (cfg.key_mode)
                KM_FULL: match[w] = row[w].src == job_reg.src && row[w].dst == job_reg.dst
                                    && row[w].flow == job_reg.flow;
                KM_PAIR: match[w] = row[w].src == job_reg.src && row[w].dst == job_reg.dst;
                KM_FLOW: match[w] = row[w].flow == job_reg.flow;
                default: match[w] = row[w].dst == job_reg.dst;
            endcase
            match[w] = match[w] && row[w].valid;
        end
        hit     = |match;
        hit_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_idx = IW'(w);
            end
        end
    end

    always_comb
    begin
        logic [PW-1:0] p;
        ne.valid   = 1'b1;
        ne.src     = job_reg.src;
        ne.dst     = job_reg.dst;
        ne.flow    = job_reg.flow;
        ne.slot    = job_reg.slot_value;
        new_row    = row;
        row_write  = 1'b0;
        res_status = ST_HIT;
        res_slot   = '0;
        p          = '0;
        case (job_reg.cmd)
            CMD_CLASSIFY:
            begin
                if (hit)
                begin
                    res_slot = row[hit_idx].slot;
                end
                else if (!cfg.default_slot[DSLOT_W-1])
                begin
                    res_status = ST_DEFAULT;
                    res_slot   = cfg.default_slot[SLOT_W-1:0];
                end
                else
                begin
                    res_status = ST_UNKNOWN;
                end
            end
            CMD_INSERT:
            begin
                if (job_reg.bad)
                begin
                    res_status = ST_BAD;
                end
                else if (!row[0].valid)
                begin
                    new_row[0] = ne;
                    row_write  = 1'b1;
                end
                else
                begin
                    // new entry heads the chain, live chain entries follow in order
                    for (int w = 1; w < WAYS; w++)
                    begin
                        new_row[w] = (w == 1) ? ne : '0;
                    end
                    for (int w = 1; w < WAYS; w++)
                    begin
                        if (row[w].valid)
                        begin
                            if (32'(p) < WAYS - 2)
                            begin
                                new_row[p + 2] = row[w];
                            end
                            p = p + 1'b1;
                        end
                    end
                    if (32'(p) >= WAYS - 1)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        row_write = 1'b1;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                if (job_reg.bad)
                begin
                    res_status = ST_BAD;
                end
                else if (hit)
                begin
                    res_slot = row[hit_idx].slot;
                end
                else
                begin
                    res_status = ST_MISS;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    res_slot                = row[hit_idx].slot;
                    new_row[hit_idx].valid  = 1'b0;
                    row_write               = 1'b1;
                end
                else
                begin
                    res_status = ST_MISS;
                end
            end
            default:
            begin
                res_status = ST_HIT;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_cnt_reg == AW'(NBUCKETS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (out_free)
                begin
                    state_next = (job_reg.cmd == CMD_CLEAR) ? B_CLEAR : B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        clearing  = (state_reg == B_CLEAR);
        q_pop     = (state_reg == B_IDLE) && !q_empty;
        ram_re    = q_pop;
        load      = (state_reg == B_EXEC) && out_free;
        ram_we    = clearing || (load && row_write);
        ram_waddr = clearing ? clr_cnt_reg : AW'(job_reg.bucket);
        ram_wdata = clearing ? '0 : new_row;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign bucket    = bucket_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (load)
        begin
            status_reg <= res_status;
            slot_reg   <= res_slot;
            bucket_reg <= job_reg.bucket[BKT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/flow_hash_classifier_top.sv =====
// channel  | handshake           | payload
// in       | in_valid / in_stall | command, src_addr, dst_addr, flow_id, bucket_auto,
//          |                     | bucket_index, slot_value
// out      | out_valid/out_stall | status, slot, bucket
// cfg      | cfg_write           | cfg_index, cfg_data
//
// an item goes through accept, 8 steps of the 4-bit remainder unit, queue push,
// then table read and write-back in the back end
// after reset and after a clear item the table is swept, one bucket row per cycle,
// all NBUCKETS rows; no item is accepted during the sweep, cfg writes still are
// results sit in an output register; the back end waits on out_stall, the front end on a
// full queue
module flow_hash_classifier_top import fhc_pkg::*; #(
    parameter int NBUCKETS = NBUCKETS_DEF,
    parameter int WAYS     = WAYS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [KEY_W-1:0]     src_addr,
    input  logic [KEY_W-1:0]     dst_addr,
    input  logic [KEY_W-1:0]     flow_id,
    input  logic                 bucket_auto,
    input  logic [BKT_W-1:0]     bucket_index,
    input  logic [SLOT_W-1:0]    slot_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STAT_W-1:0]    status,
    output logic [SLOT_W-1:0]    slot,
    output logic [BKT_W-1:0]     bucket
);

    cfg_t cfg_reg;
    job_t push_job, pop_job;
    logic q_push, q_pop, q_full, q_empty, clearing;
    logic [$bits(job_t)-1:0] pop_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_mode     <= KM_FULL;
            cfg_reg.num_buckets  <= NB_W'(1024);
            cfg_reg.default_slot <= '1;
            cfg_reg.addr_shift   <= '0;
            cfg_reg.addr_mask    <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_MODE:     cfg_reg.key_mode     <= cfg_data[MODE_W-1:0];
                REG_NUM_BUCKETS:  cfg_reg.num_buckets  <= cfg_data[NB_W-1:0];
                REG_DEFAULT_SLOT: cfg_reg.default_slot <= cfg_data[DSLOT_W-1:0];
                REG_ADDR_SHIFT:   cfg_reg.addr_shift   <= cfg_data[SHIFT_W-1:0];
                REG_ADDR_MASK:    cfg_reg.addr_mask    <= cfg_data[KEY_W-1:0];
                default:          cfg_reg.key_mode     <= cfg_reg.key_mode;
            endcase
        end
    end

    fhc_front #(
        .NBUCKETS (NBUCKETS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .flow_id      (flow_id),
        .bucket_auto  (bucket_auto),
        .bucket_index (bucket_index),
        .slot_value   (slot_value),
        .clearing     (clearing),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    fhc_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (push_job),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (pop_bits),
        .empty (q_empty)
    );

    assign pop_job = pop_bits;

    fhc_back #(
        .NBUCKETS (NBUCKETS),
        .WAYS     (WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_job     (pop_job),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot      (slot),
        .bucket    (bucket)
    );

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("item accepted during table sweep");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue underflow");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_BAD))
        else $error("illegal status code");

endmodule
